FILE: rtl/minimum_error_histogram_threshold_core_assert.svh
// Assertion macros for the minimum-error threshold core checker.
// Needs a clock i_clk and an active-low reset i_rst_n in the using scope.
`ifndef MINIMUM_ERROR_HISTOGRAM_THRESHOLD_CORE_ASSERT_SVH
`define MINIMUM_ERROR_HISTOGRAM_THRESHOLD_CORE_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent
`define MEHT_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent
`define MEHT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/meht_pkg.sv
// Shared types and constants of the minimum-error threshold core.
// No dependencies; used by the top level, the search engine, the log2 unit, the checker and the testbench.
package meht_pkg;

    // Default sizes
    localparam int LEVEL_BITS_DEF = 8;
    localparam int COUNT_BITS_DEF = 32;

    // Log2 format: fraction bits and width of the normalized mantissa
    localparam int FRAC_BITS = 16;
    localparam int Y_BITS    = 32;

    // Width of the threshold result field
    localparam int THRESH_W = 8;

    // Command codes
    typedef enum logic [1:0] {
        CMD_ADD      = 2'd0,
        CMD_COMPUTE  = 2'd1,
        CMD_CLASSIFY = 2'd2,
        CMD_CLEAR    = 2'd3
    } t_cmd;

    // Result kinds
    localparam logic KIND_THRESH = 1'b0;
    localparam logic KIND_LABEL  = 1'b1;

    // Threshold search sequencer
    typedef enum logic [3:0] {
        E_IDLE,
        E_RD,
        E_DAT,
        E_MOM1,
        E_MOM2,
        E_ACC,
        E_SEL,
        E_MUL_NS2,
        E_MUL_SQ,
        E_LOG_N,
        E_LOG_D,
        E_WT,
        E_MUL_W,
        E_CMP,
        E_DONE
    } t_eng_state;

    // Log2 unit sequencer
    typedef enum logic [1:0] {
        LG_IDLE,
        LG_NORM,
        LG_MUL,
        LG_STEP
    } t_log_state;

    // Control from the top level to the search engine
    typedef struct packed {
        logic start;
    } t_eng_ctl;

    // Status from the search engine to the top level
    typedef struct packed {
        logic busy;
        logic done;
    } t_eng_stat;

endpackage

FILE: rtl/minimum_error_histogram_threshold_core.sv
// Top level of the minimum-error (Kittler-Illingworth) histogram threshold core.
// Depends on meht_pkg, meht_ram and meht_engine.
//
// Add-pixel and classify commands are taken one per clock while the core does
// not stall; each add is a read-modify-write of one histogram bin in the RAM,
// with the write of the previous cycle forwarded so the same gray level may
// repeat back to back. A classify result appears in the output register in the
// cycle after its transfer. A compute command holds the input for two sweeps
// over the 2^LEVEL_BITS bins plus, for every level, two class terms on a shared
// shift-add multiplier (three products per term) and a shared log2 unit (a
// serial normalize, then one squaring step per fraction bit; up to two logs
// per term, the second skipped at zero variance). After reset and after every
// clear command a clearing pass writes zero to one bin per cycle over all
// 2^LEVEL_BITS bins, and no command is taken until it ends.
module minimum_error_histogram_threshold_core #(
    parameter int LEVEL_BITS = meht_pkg::LEVEL_BITS_DEF,
    parameter int COUNT_BITS = meht_pkg::COUNT_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [1:0]                    i_cmd,
    input  logic [7:0]                    i_pixel,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_kind,
    output logic [meht_pkg::THRESH_W-1:0] o_threshold,
    output logic                          o_label
);

    localparam int L = LEVEL_BITS;
    localparam int C = COUNT_BITS;

    meht_pkg::t_cmd       w_cmd;
    logic [L-1:0]         w_pix;
    logic                 w_accept;
    meht_pkg::t_eng_ctl   eng_ctl;
    meht_pkg::t_eng_stat  eng_stat;
    logic [L-1:0]         eng_raddr;
    logic [L-1:0]         eng_thr;

    logic                 ram_we;
    logic [L-1:0]         ram_waddr;
    logic [C-1:0]         ram_wdata;
    logic [L-1:0]         ram_raddr;
    logic [C-1:0]         ram_rdata;

    logic                 r_clr_active;
    logic [L-1:0]         r_clr_addr;
    logic                 r_a_vld;
    logic [L-1:0]         r_a_addr;
    logic                 r_fwd_vld;
    logic [L-1:0]         r_fwd_addr;
    logic [C-1:0]         r_fwd_data;
    logic [L-1:0]         r_held;
    logic                 r_o_valid;
    logic                 r_o_kind;
    logic [meht_pkg::THRESH_W-1:0] r_o_thr;
    logic                 r_o_label;

    logic [C-1:0]         w_cur;
    logic [C-1:0]         w_inc;

    assign w_cmd    = meht_pkg::t_cmd'(i_cmd);
    assign w_pix    = L'(i_pixel);
    assign o_stall  = r_clr_active || eng_stat.busy || (r_o_valid && i_stall);
    assign w_accept = i_valid && !o_stall;

    assign eng_ctl.start = w_accept && (w_cmd == meht_pkg::CMD_COMPUTE);

    // Histogram store
    meht_ram #(
        .WIDTH(C),
        .DEPTH(2 ** L)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Threshold search
    meht_engine #(
        .LEVEL_BITS(L),
        .COUNT_BITS(C)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (eng_ctl),
        .o_stat      (eng_stat),
        .o_raddr     (eng_raddr),
        .i_rdata     (ram_rdata),
        .o_threshold (eng_thr)
    );

    // Forward last cycle's write, then saturate the increment
    assign w_cur = (r_fwd_vld && r_fwd_addr == r_a_addr) ? r_fwd_data : ram_rdata;
    assign w_inc = (&w_cur) ? w_cur : w_cur + C'(1);

    // RAM port selection
    assign ram_raddr = eng_stat.busy ? eng_raddr : w_pix;
    assign ram_we    = r_clr_active || r_a_vld;
    assign ram_waddr = r_clr_active ? r_clr_addr : r_a_addr;
    assign ram_wdata = r_clr_active ? '0 : w_inc;

    // Control: clearing pass, add stage, forwarding valid, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_active <= 1'b1;
            r_clr_addr   <= '0;
            r_a_vld      <= 1'b0;
            r_fwd_vld    <= 1'b0;
            r_held       <= '0;
            r_o_valid    <= 1'b0;
        end else begin
            r_a_vld   <= w_accept && (w_cmd == meht_pkg::CMD_ADD);
            r_fwd_vld <= ram_we;
            if (w_accept && w_cmd == meht_pkg::CMD_CLEAR) begin
                r_clr_active <= 1'b1;
                r_clr_addr   <= '0;
            end else if (r_clr_active) begin
                r_clr_addr <= r_clr_addr + L'(1);
                if (&r_clr_addr) begin
                    r_clr_active <= 1'b0;
                end
            end
            if (eng_stat.done) begin
                r_held <= eng_thr;
            end
            if (w_accept && w_cmd == meht_pkg::CMD_CLASSIFY) begin
                r_o_valid <= 1'b1;
            end else if (eng_stat.done) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Payload: add stage address, forwarded write, result fields
    always_ff @(posedge i_clk) begin
        r_a_addr   <= w_pix;
        r_fwd_addr <= ram_waddr;
        r_fwd_data <= ram_wdata;
        if (w_accept && w_cmd == meht_pkg::CMD_CLASSIFY) begin
            r_o_kind  <= meht_pkg::KIND_LABEL;
            r_o_thr   <= meht_pkg::THRESH_W'(r_held);
            r_o_label <= (w_pix > r_held);
        end else if (eng_stat.done) begin
            r_o_kind  <= meht_pkg::KIND_THRESH;
            r_o_thr   <= meht_pkg::THRESH_W'(eng_thr);
            r_o_label <= 1'b0;
        end
    end

    assign o_valid     = r_o_valid;
    assign o_kind      = r_o_kind;
    assign o_threshold = r_o_thr;
    assign o_label     = r_o_label;

endmodule

FILE: rtl/meht_ram.sv
// Generic single-clock RAM, one write port and one registered read port.
// No dependencies.
module meht_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write, then register the read word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/meht_mul.sv
// Shift-add multiplier, one operand bit per cycle.
// No dependencies; used by the search engine.
module meht_mul #(
    parameter int OW = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [OW-1:0]   i_a,
    input  logic [OW-1:0]   i_b,
    output logic            o_done,
    output logic [2*OW-1:0] o_prod
);

    localparam int CNTW = $clog2(OW);

    logic            r_busy;
    logic            r_done;
    logic [CNTW-1:0] r_cnt;
    logic [2*OW-1:0] r_a;
    logic [OW-1:0]   r_b;
    logic [2*OW-1:0] r_acc;
    logic            w_last;

    assign w_last = (r_cnt == CNTW'(OW - 1));

    // Control: busy flag and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && w_last;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && w_last) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Datapath: add the shifted multiplicand for each set multiplier bit
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= {{OW{1'b0}}, i_a};
            r_b   <= i_b;
            r_acc <= '0;
            r_cnt <= '0;
        end else if (r_busy) begin
            if (r_b[0]) begin
                r_acc <= r_acc + r_a;
            end
            r_a   <= r_a << 1;
            r_b   <= r_b >> 1;
            r_cnt <= r_cnt + CNTW'(1);
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

FILE: rtl/meht_log.sv
// Fixed-point log2 unit: serial normalize, then one squaring step per fraction bit.
// Depends on meht_pkg.
module meht_log #(
    parameter int XW = 144
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_start,
    input  logic [XW-1:0]                            i_x,
    output logic                                     o_done,
    output logic [$clog2(XW)+meht_pkg::FRAC_BITS-1:0] o_lg
);

    localparam int KBW = $clog2(XW);
    localparam int FB  = meht_pkg::FRAC_BITS;
    localparam int YB  = meht_pkg::Y_BITS;
    localparam int BW  = $clog2(FB);

    meht_pkg::t_log_state r_state, n_state;
    logic                 r_done, n_done;
    logic [XW-1:0]        r_x, n_x;
    logic [KBW-1:0]       r_k, n_k;
    logic [YB-1:0]        r_y, n_y;
    logic [2*YB-1:0]      r_sq, n_sq;
    logic [FB-1:0]        r_frac, n_frac;
    logic [BW-1:0]        r_bit, n_bit;
    logic [KBW+FB-1:0]    r_lg, n_lg;
    logic [YB:0]          w_z;

    assign w_z = r_sq[2*YB-1:YB-1];

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= meht_pkg::LG_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_x    <= n_x;
        r_k    <= n_k;
        r_y    <= n_y;
        r_sq   <= n_sq;
        r_frac <= n_frac;
        r_bit  <= n_bit;
        r_lg   <= n_lg;
    end

    // Next state: normalize, square, take one fraction bit
    always_comb begin
        n_state = r_state;
        n_done  = 1'b0;
        n_x     = r_x;
        n_k     = r_k;
        n_y     = r_y;
        n_sq    = r_sq;
        n_frac  = r_frac;
        n_bit   = r_bit;
        n_lg    = r_lg;
        unique case (r_state)
            meht_pkg::LG_IDLE: begin
                if (i_start) begin
                    if (i_x == '0) begin
                        n_lg   = '0;
                        n_done = 1'b1;
                    end else begin
                        n_x     = i_x;
                        n_k     = KBW'(XW - 1);
                        n_state = meht_pkg::LG_NORM;
                    end
                end
            end
            meht_pkg::LG_NORM: begin
                if (r_x[XW-1]) begin
                    n_y     = r_x[XW-1 -: YB];
                    n_frac  = '0;
                    n_bit   = BW'(FB - 1);
                    n_state = meht_pkg::LG_MUL;
                end else begin
                    n_x = r_x << 1;
                    n_k = r_k - KBW'(1);
                end
            end
            meht_pkg::LG_MUL: begin
                n_sq    = r_y * r_y;
                n_state = meht_pkg::LG_STEP;
            end
            meht_pkg::LG_STEP: begin
                n_frac[r_bit] = w_z[YB];
                n_y = w_z[YB] ? w_z[YB:1] : w_z[YB-1:0];
                if (r_bit == '0) begin
                    n_lg    = {r_k, n_frac};
                    n_done  = 1'b1;
                    n_state = meht_pkg::LG_IDLE;
                end else begin
                    n_bit   = r_bit - BW'(1);
                    n_state = meht_pkg::LG_MUL;
                end
            end
            default: n_state = meht_pkg::LG_IDLE;
        endcase
    end

    assign o_done = r_done;
    assign o_lg   = r_lg;

endmodule

FILE: rtl/meht_engine.sv
// Threshold search engine: two sweeps over the histogram RAM, criterion per level.
// Depends on meht_pkg, meht_mul and meht_log.
module meht_engine #(
    parameter int LEVEL_BITS = meht_pkg::LEVEL_BITS_DEF,
    parameter int COUNT_BITS = meht_pkg::COUNT_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  meht_pkg::t_eng_ctl    i_ctl,
    output meht_pkg::t_eng_stat   o_stat,
    output logic [LEVEL_BITS-1:0] o_raddr,
    input  logic [COUNT_BITS-1:0] i_rdata,
    output logic [LEVEL_BITS-1:0] o_threshold
);

    localparam int L    = LEVEL_BITS;
    localparam int C    = COUNT_BITS;
    localparam int NW   = C + L;
    localparam int S1W  = C + 2 * L;
    localparam int S2W  = C + 3 * L;
    localparam int DW   = 2 * C + 4 * L;
    localparam int LGU  = $clog2(DW) + meht_pkg::FRAC_BITS;
    localparam int LGW  = LGU + 3;
    localparam int OW   = (S2W > LGW) ? S2W : LGW;
    localparam int SW   = DW + 2;
    localparam logic [L-1:0] LAST = {L{1'b1}};

    meht_pkg::t_eng_state r_state, n_state;
    logic                 r_issued, n_issued;
    logic [L-1:0]         r_v, n_v;
    logic                 r_pass, n_pass;
    logic                 r_cls, n_cls;
    logic [C-1:0]         r_cnt, n_cnt;
    logic [NW-1:0]        r_m1, n_m1;
    logic [S1W-1:0]       r_m2, n_m2;
    logic [NW-1:0]        r_tn, n_tn, r_pn, n_pn, r_n, n_n;
    logic [S1W-1:0]       r_t1, n_t1, r_p1, n_p1, r_s1, n_s1;
    logic [S2W-1:0]       r_t2, n_t2, r_p2, n_p2, r_s2, n_s2;
    logic [DW-1:0]        r_d, n_d;
    logic [LGU-1:0]       r_ln, n_ln, r_ld, n_ld;
    logic signed [LGW-1:0] r_wt, n_wt;
    logic signed [SW-1:0] r_sum, n_sum, r_best, n_best;
    logic [L-1:0]         r_tbest, n_tbest;

    logic                 mul_start, mul_done;
    logic [OW-1:0]        mul_a, mul_b;
    logic [2*OW-1:0]      mul_prod;
    logic                 log_start, log_done;
    logic [DW-1:0]        log_x;
    logic [LGU-1:0]       log_lg;

    logic                 w_d_zero;
    logic signed [LGW-1:0] w_ln_s, w_ld_s;
    logic [LGW-1:0]       w_wt_mag;
    logic [SW-1:0]        w_mag;
    logic signed [SW-1:0] w_term;

    assign w_d_zero = (r_d == '0);
    assign w_ln_s   = $signed({3'b000, r_ln});
    assign w_ld_s   = $signed({3'b000, r_ld});
    assign w_wt_mag = r_wt[LGW-1] ? LGW'(-r_wt) : LGW'(r_wt);
    assign w_mag    = mul_prod[SW-1:0];
    assign w_term   = r_wt[LGW-1] ? -$signed(w_mag) : $signed(w_mag);

    // Shared serial multiplier
    meht_mul #(
        .OW(OW)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    // Shared log2 unit
    meht_log #(
        .XW(DW)
    ) u_log (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (log_start),
        .i_x     (log_x),
        .o_done  (log_done),
        .o_lg    (log_lg)
    );

    // Route operands to the shared units
    always_comb begin
        mul_a = OW'(r_n);
        mul_b = OW'(r_s2);
        log_x = DW'(r_n);
        case (r_state)
            meht_pkg::E_MUL_SQ: begin
                mul_a = OW'(r_s1);
                mul_b = OW'(r_s1);
            end
            meht_pkg::E_MUL_W: begin
                mul_b = OW'(w_wt_mag);
            end
            meht_pkg::E_LOG_D: begin
                log_x = r_d;
            end
            default: begin
                mul_a = OW'(r_n);
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= meht_pkg::E_IDLE;
            r_issued <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_issued <= n_issued;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_v     <= n_v;
        r_pass  <= n_pass;
        r_cls   <= n_cls;
        r_cnt   <= n_cnt;
        r_m1    <= n_m1;
        r_m2    <= n_m2;
        r_tn    <= n_tn;
        r_t1    <= n_t1;
        r_t2    <= n_t2;
        r_pn    <= n_pn;
        r_p1    <= n_p1;
        r_p2    <= n_p2;
        r_n     <= n_n;
        r_s1    <= n_s1;
        r_s2    <= n_s2;
        r_d     <= n_d;
        r_ln    <= n_ln;
        r_ld    <= n_ld;
        r_wt    <= n_wt;
        r_sum   <= n_sum;
        r_best  <= n_best;
        r_tbest <= n_tbest;
    end

    // Sequencer: totals sweep, then prefix sweep with two class terms per level
    always_comb begin
        n_state   = r_state;
        n_issued  = r_issued;
        n_v       = r_v;
        n_pass    = r_pass;
        n_cls     = r_cls;
        n_cnt     = r_cnt;
        n_m1      = r_m1;
        n_m2      = r_m2;
        n_tn      = r_tn;
        n_t1      = r_t1;
        n_t2      = r_t2;
        n_pn      = r_pn;
        n_p1      = r_p1;
        n_p2      = r_p2;
        n_n       = r_n;
        n_s1      = r_s1;
        n_s2      = r_s2;
        n_d       = r_d;
        n_ln      = r_ln;
        n_ld      = r_ld;
        n_wt      = r_wt;
        n_sum     = r_sum;
        n_best    = r_best;
        n_tbest   = r_tbest;
        mul_start = 1'b0;
        log_start = 1'b0;
        unique case (r_state)
            meht_pkg::E_IDLE: begin
                if (i_ctl.start) begin
                    n_v     = '0;
                    n_pass  = 1'b0;
                    n_tn    = '0;
                    n_t1    = '0;
                    n_t2    = '0;
                    n_pn    = '0;
                    n_p1    = '0;
                    n_p2    = '0;
                    n_state = meht_pkg::E_RD;
                end
            end
            meht_pkg::E_RD: begin
                n_state = meht_pkg::E_DAT;
            end
            meht_pkg::E_DAT: begin
                n_cnt   = i_rdata;
                n_state = meht_pkg::E_MOM1;
            end
            meht_pkg::E_MOM1: begin
                n_m1    = NW'(r_cnt) * NW'(r_v);
                n_state = meht_pkg::E_MOM2;
            end
            meht_pkg::E_MOM2: begin
                n_m2    = S1W'(r_m1) * S1W'(r_v);
                n_state = meht_pkg::E_ACC;
            end
            meht_pkg::E_ACC: begin
                if (!r_pass) begin
                    n_tn = r_tn + NW'(r_cnt);
                    n_t1 = r_t1 + S1W'(r_m1);
                    n_t2 = r_t2 + S2W'(r_m2);
                    if (r_v == LAST) begin
                        n_v    = '0;
                        n_pass = 1'b1;
                    end else begin
                        n_v = r_v + L'(1);
                    end
                    n_state = meht_pkg::E_RD;
                end else begin
                    n_pn    = r_pn + NW'(r_cnt);
                    n_p1    = r_p1 + S1W'(r_m1);
                    n_p2    = r_p2 + S2W'(r_m2);
                    n_cls   = 1'b0;
                    n_state = meht_pkg::E_SEL;
                end
            end
            meht_pkg::E_SEL: begin
                n_n     = r_cls ? r_tn - r_pn : r_pn;
                n_s1    = r_cls ? r_t1 - r_p1 : r_p1;
                n_s2    = r_cls ? r_t2 - r_p2 : r_p2;
                n_state = meht_pkg::E_MUL_NS2;
            end
            meht_pkg::E_MUL_NS2: begin
                if (!r_issued) begin
                    mul_start = 1'b1;
                    n_issued  = 1'b1;
                end else if (mul_done) begin
                    n_issued = 1'b0;
                    n_d      = mul_prod[DW-1:0];
                    n_state  = meht_pkg::E_MUL_SQ;
                end
            end
            meht_pkg::E_MUL_SQ: begin
                if (!r_issued) begin
                    mul_start = 1'b1;
                    n_issued  = 1'b1;
                end else if (mul_done) begin
                    n_issued = 1'b0;
                    n_d      = r_d - mul_prod[DW-1:0];
                    n_state  = meht_pkg::E_LOG_N;
                end
            end
            meht_pkg::E_LOG_N: begin
                if (!r_issued) begin
                    log_start = 1'b1;
                    n_issued  = 1'b1;
                end else if (log_done) begin
                    n_issued = 1'b0;
                    n_ln     = log_lg;
                    n_state  = w_d_zero ? meht_pkg::E_WT : meht_pkg::E_LOG_D;
                end
            end
            meht_pkg::E_LOG_D: begin
                if (!r_issued) begin
                    log_start = 1'b1;
                    n_issued  = 1'b1;
                end else if (log_done) begin
                    n_issued = 1'b0;
                    n_ld     = log_lg;
                    n_state  = meht_pkg::E_WT;
                end
            end
            meht_pkg::E_WT: begin
                // zero variance drops the variance log
                n_wt    = w_d_zero ? -(w_ln_s <<< 1) : w_ld_s - (w_ln_s <<< 2);
                n_state = meht_pkg::E_MUL_W;
            end
            meht_pkg::E_MUL_W: begin
                if (!r_issued) begin
                    mul_start = 1'b1;
                    n_issued  = 1'b1;
                end else if (mul_done) begin
                    n_issued = 1'b0;
                    if (!r_cls) begin
                        n_sum   = w_term;
                        n_cls   = 1'b1;
                        n_state = meht_pkg::E_SEL;
                    end else begin
                        n_sum   = r_sum + w_term;
                        n_state = meht_pkg::E_CMP;
                    end
                end
            end
            meht_pkg::E_CMP: begin
                // strict compare keeps the lowest level on ties
                if (r_v == '0 || r_sum < r_best) begin
                    n_best  = r_sum;
                    n_tbest = r_v;
                end
                if (r_v == LAST) begin
                    n_state = meht_pkg::E_DONE;
                end else begin
                    n_v     = r_v + L'(1);
                    n_state = meht_pkg::E_RD;
                end
            end
            meht_pkg::E_DONE: begin
                n_state = meht_pkg::E_IDLE;
            end
            default: n_state = meht_pkg::E_IDLE;
        endcase
    end

    assign o_stat.busy = (r_state != meht_pkg::E_IDLE);
    assign o_stat.done = (r_state == meht_pkg::E_DONE);
    assign o_raddr     = r_v;
    assign o_threshold = r_tbest;

endmodule

FILE: rtl/meht_checker.sv
// Port-level checker for the minimum-error threshold core, bound to the top level.
// Depends on meht_pkg and minimum_error_histogram_threshold_core_assert.svh.
`include "minimum_error_histogram_threshold_core_assert.svh"

module meht_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic [1:0] i_cmd,
    input logic       o_valid,
    input logic       i_stall,
    input logic       o_kind,
    input logic [7:0] o_threshold,
    input logic       o_label
);

    logic w_in_xfer;

    assign w_in_xfer = i_valid && !o_stall;

    // A classify transfer shows its label result in the next cycle
    `MEHT_ASSERT_NEXT(a_classify_result, w_in_xfer && i_cmd == meht_pkg::CMD_CLASSIFY, o_valid && o_kind == meht_pkg::KIND_LABEL, "classify gave no label result")
    // A compute transfer holds the input while the search runs
    `MEHT_ASSERT_NEXT(a_compute_holds, w_in_xfer && i_cmd == meht_pkg::CMD_COMPUTE, o_stall, "input not held during compute")
    // Add and clear make no result
    `MEHT_ASSERT_NEXT(a_no_spurious, w_in_xfer && (i_cmd == meht_pkg::CMD_ADD || i_cmd == meht_pkg::CMD_CLEAR) && !o_valid, !o_valid, "result after add or clear")
    // A threshold result carries a zero label
    `MEHT_ASSERT_SAME(a_thresh_label, o_valid && o_kind == meht_pkg::KIND_THRESH, !o_label, "label set on threshold result")
    // A stalled result holds
    `MEHT_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_kind) && $stable(o_threshold) && $stable(o_label), "stalled result changed")

endmodule

bind minimum_error_histogram_threshold_core meht_checker u_meht_checker (.*);

FILE: tb/tb_top.sv
// Self-checking testbench of minimum_error_histogram_threshold_core: pixel adds,
// threshold searches, classify and clear commands, checked against a local predictor.
// Depends on meht_pkg and the core RTL.
module tb_top;

    typedef struct {
        meht_pkg::t_cmd cmd;
        logic [7:0]     pix;
        bit             drain;   // wait for all results before offering this one
    } t_pix_cmd;

    typedef struct {
        logic       kind;
        logic [7:0] thr;
        logic       label;
    } t_outcome;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic [1:0] i_cmd = meht_pkg::CMD_ADD;
    logic [7:0] i_pixel = 8'd0;
    logic       i_stall = 1'b0;
    logic       o_stall, o_valid, o_kind, o_label;
    logic [meht_pkg::THRESH_W-1:0] o_threshold;

    t_pix_cmd cmd_q[$];
    t_outcome outcome_q[$];

    // predictor state
    logic [31:0] hist[256];
    logic [7:0]  held_thr;

    int fails = 0;
    int cyc = 0;
    int cyc_limit = 0;
    int n_add = 0, n_comp = 0, n_cls = 0, n_clr = 0, n_res = 0;
    int tx_gap = 0, rx_wait = 0, rx_hold = 0;
    bit hold_done = 1'b0;

    minimum_error_histogram_threshold_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_cmd(i_cmd), .i_pixel(i_pixel),
        .o_valid(o_valid), .i_stall(i_stall), .o_kind(o_kind),
        .o_threshold(o_threshold), .o_label(o_label)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Base-2 log in Q.16: normalize to 32 significant bits, then square 16 times
    function automatic longint log2_q16(input logic [191:0] x);
        int k;
        logic [31:0] y;
        logic [63:0] z;
        logic [15:0] fr;
        if (x == 0) return 0;
        k = 0;
        for (int i = 0; i < 192; i++) if (x[i]) k = i;
        if (k >= 31) y = 32'(x >> (k - 31));
        else y = 32'(x << (31 - k));
        fr = '0;
        for (int i = 15; i >= 0; i--) begin
            z = ({32'b0, y} * {32'b0, y}) >> 31;
            if (z[63:32] != 0) begin
                fr[i] = 1'b1;
                z = z >> 1;
            end
            y = z[31:0];
        end
        return longint'(k) * 65536 + longint'(fr);
    endfunction

    // Cost of one class: n*log2(n*S2-S1^2) - 4n*log2(n), or -2n*log2(n) at zero spread
    function automatic logic signed [191:0] class_cost(input logic signed [191:0] n,
                                                       input logic signed [191:0] s1,
                                                       input logic signed [191:0] s2);
        logic signed [191:0] d, w;
        longint ln, wt;
        d = n * s2 - s1 * s1;
        ln = log2_q16(n);
        wt = (d == 0) ? -2 * ln : log2_q16(d) - 4 * ln;
        w = wt;
        return n * w;
    endfunction

    // Sweep every threshold and keep the lowest one with minimum cost
    function automatic logic [7:0] best_threshold();
        logic signed [191:0] tn, t1, t2, pn, p1, p2, c, m1, cost, best;
        logic [7:0] tb;
        tn = 0; t1 = 0; t2 = 0;
        for (int v = 0; v < 256; v++) begin
            c = hist[v];
            m1 = c * v;
            tn += c; t1 += m1; t2 += m1 * v;
        end
        pn = 0; p1 = 0; p2 = 0; best = 0; tb = 8'd0;
        for (int v = 0; v < 256; v++) begin
            c = hist[v];
            m1 = c * v;
            pn += c; p1 += m1; p2 += m1 * v;
            cost = class_cost(pn, p1, p2) + class_cost(tn - pn, t1 - p1, t2 - p2);
            if (v == 0 || cost < best) begin
                best = cost;
                tb = 8'(v);
            end
        end
        return tb;
    endfunction

    // Advance the predictor by one accepted command
    task automatic apply_cmd(input logic [1:0] cmd, input logic [7:0] pix);
        t_outcome o;
        case (cmd)
            meht_pkg::CMD_ADD: begin
                if (hist[pix] != 32'hFFFF_FFFF) hist[pix] = hist[pix] + 1;
                n_add++;
            end
            meht_pkg::CMD_CLEAR: begin
                foreach (hist[i]) hist[i] = '0;
                n_clr++;
            end
            meht_pkg::CMD_COMPUTE: begin
                held_thr = best_threshold();
                o.kind = meht_pkg::KIND_THRESH; o.thr = held_thr; o.label = 1'b0;
                outcome_q.push_back(o);
                n_comp++;
            end
            default: begin
                o.kind = meht_pkg::KIND_LABEL; o.thr = held_thr; o.label = (pix > held_thr);
                outcome_q.push_back(o);
                n_cls++;
            end
        endcase
    endtask

    function automatic void add_cmd(input meht_pkg::t_cmd c, input logic [7:0] p,
                                    input bit dr = 1'b0);
        t_pix_cmd it;
        it.cmd = c; it.pix = p; it.drain = dr;
        cmd_q.push_back(it);
    endfunction

    // Drive commands: one transfer per accepted valid, random gaps with idle-free stretches
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) apply_cmd(i_cmd, i_pixel);
            if (!i_valid || !o_stall) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    i_valid <= 1'b0;
                end else if (cmd_q.size() > 0 &&
                             (!cmd_q[0].drain || (outcome_q.size() == 0 && !i_valid))) begin
                    i_valid <= 1'b1;
                    i_cmd   <= cmd_q[0].cmd;
                    i_pixel <= cmd_q[0].pix;
                    void'(cmd_q.pop_front());
                    tx_gap = ((cyc / 300) % 3 == 0) ? 0 : $urandom_range(0, 4);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Check results in order and drive the receiver stall
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                n_res++;
                if (outcome_q.size() == 0) begin
                    $error("unexpected result kind=%0d threshold=%0d", o_kind, o_threshold);
                    fails++;
                end else begin
                    if (o_kind !== outcome_q[0].kind) begin
                        $error("kind: expected %0d, got %0d", outcome_q[0].kind, o_kind);
                        fails++;
                    end
                    if (o_threshold !== outcome_q[0].thr) begin
                        $error("threshold: expected %0d, got %0d", outcome_q[0].thr,
                               o_threshold);
                        fails++;
                    end
                    if (o_label !== outcome_q[0].label) begin
                        $error("label: expected %0d, got %0d", outcome_q[0].label, o_label);
                        fails++;
                    end
                    void'(outcome_q.pop_front());
                end
                rx_wait = ((cyc / 250) % 3 == 1) ? 0 : $urandom_range(0, 4);
                if (!hold_done && n_res >= 120) begin
                    rx_hold = 400;
                    hold_done = 1'b1;
                end
            end
            if (rx_hold > 0) begin
                rx_hold--;
                i_stall <= 1'b1;
            end else if (rx_wait > 0) begin
                rx_wait--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Cycle budget
    always @(posedge i_clk) begin
        cyc++;
        if (cyc_limit > 0 && cyc > cyc_limit) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    initial begin
        int mode, c1, c2, spread, p, ncomp;
        foreach (hist[i]) hist[i] = '0;
        held_thr = '0;

        // directed: empty search, extremes, single level, clear keeps threshold
        add_cmd(meht_pkg::CMD_COMPUTE, 8'd0);
        add_cmd(meht_pkg::CMD_CLASSIFY, 8'd0);
        add_cmd(meht_pkg::CMD_CLASSIFY, 8'd255);
        add_cmd(meht_pkg::CMD_ADD, 8'd255);
        add_cmd(meht_pkg::CMD_ADD, 8'd255);
        add_cmd(meht_pkg::CMD_COMPUTE, 8'hAA);
        add_cmd(meht_pkg::CMD_ADD, 8'd0);
        add_cmd(meht_pkg::CMD_ADD, 8'd0);
        add_cmd(meht_pkg::CMD_ADD, 8'd0);
        add_cmd(meht_pkg::CMD_ADD, 8'd128);
        add_cmd(meht_pkg::CMD_ADD, 8'd127);
        add_cmd(meht_pkg::CMD_COMPUTE, 8'h55, 1'b1);
        add_cmd(meht_pkg::CMD_CLASSIFY, 8'd0);
        add_cmd(meht_pkg::CMD_CLASSIFY, 8'd127);
        add_cmd(meht_pkg::CMD_CLASSIFY, 8'd128);
        add_cmd(meht_pkg::CMD_CLASSIFY, 8'd129);
        add_cmd(meht_pkg::CMD_CLASSIFY, 8'd255);
        add_cmd(meht_pkg::CMD_CLEAR, 8'hFF);
        add_cmd(meht_pkg::CMD_CLASSIFY, 8'd200);
        add_cmd(meht_pkg::CMD_COMPUTE, 8'd1);
        add_cmd(meht_pkg::CMD_CLASSIFY, 8'd1);
        ncomp = 4;

        // random: histogram segments of uniform or two-mode gray levels
        mode = 0; c1 = 60; c2 = 190; spread = 20;
        for (int i = 0; i < 1400; i++) begin
            if (i % 450 == 0) begin
                mode = $urandom_range(0, 2);
                c1 = $urandom_range(0, 127);
                c2 = $urandom_range(128, 255);
                spread = $urandom_range(1, 40);
            end
            if (mode == 0) p = $urandom_range(0, 255);
            else begin
                p = (($urandom_range(0, 1) == 0) ? c1 : c2) +
                    $urandom_range(0, 2 * spread) - spread;
                if (p < 0) p = 0;
                if (p > 255) p = 255;
            end
            if (i % 450 == 449) begin
                add_cmd(meht_pkg::CMD_COMPUTE, 8'($urandom), 1'b1);
                ncomp++;
            end else if (i % 450 == 0 && i > 0) begin
                add_cmd(meht_pkg::CMD_CLEAR, 8'($urandom));
            end else if ($urandom_range(0, 99) < 60) begin
                add_cmd(meht_pkg::CMD_ADD, 8'(p));
            end else begin
                add_cmd(meht_pkg::CMD_CLASSIFY, 8'($urandom));
            end
        end
        cyc_limit = ncomp * 1500000 + 400000;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(posedge i_clk);
        while (cmd_q.size() != 0 || i_valid || outcome_q.size() != 0);
        repeat (20) @(posedge i_clk);
        if (outcome_q.size() != 0) begin
            $error("%0d results never arrived", outcome_q.size());
            fails++;
        end

        $display("Covered %0d adds, %0d classifies, %0d threshold searches, %0d clears;",
                 n_add, n_cls, n_comp, n_clr);
        $display("%0d results checked over %0d cycles, %0d mismatches.", n_res, cyc, fails);
        if (fails == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end
endmodule
